>>> rtl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_AT(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

>>> rtl/hhlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhlt_pkg
// shared types and constants of the heartbeat liveness table
// ----------------------------------------------------------------------------
package hhlt_pkg;
  localparam int MaxHosts = 2048;
  localparam int HostAw = $clog2(MaxHosts);
  localparam int ClearLen = MaxHosts;

  localparam logic [1:0] ActObserve = 2'd0;
  localparam logic [1:0] ActQuery = 2'd1;
  localparam logic [1:0] ActMark = 2'd2;
  localparam logic [1:0] ActRead = 2'd3;

  localparam logic [2:0] CfgOwnId = 3'd0;
  localparam logic [2:0] CfgOwnIot = 3'd1;
  localparam logic [2:0] CfgFail = 3'd2;
  localparam logic [2:0] CfgDead = 3'd3;
  localparam logic [2:0] CfgReqFin = 3'd4;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNoObs = 2'd1;
  localparam logic [1:0] StRange = 2'd2;

  localparam logic [2:0] HsFree = 3'd0;
  localparam logic [2:0] HsLive = 3'd1;
  localparam logic [2:0] HsUnknown = 3'd2;
  localparam logic [2:0] HsFail = 3'd3;
  localparam logic [2:0] HsDead = 3'd4;

  // record part of an entry: owner, generation, timestamp, timeout
  localparam int RecW = 12 + 64 + 64 + 16;
  // time part: first seen, last live, last request, pending request
  localparam int TimW = 4 * 32;

  typedef struct packed {
    logic [1:0] action;
    logic       bad;
    logic [HostAw-1:0] h;
    logic [11:0] host_id;
    logic [31:0] now;
    logic [11:0] owner;
    logic [63:0] gen;
    logic [63:0] ts;
    logic [15:0] iot;
    logic        req;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  host_state;
    logic [63:0] gen;
    logic [63:0] ts;
    logic [15:0] iot;
    logic        changed;
    logic        new_req;
    logic        bit_out;
  } res_t;

  typedef enum logic [1:0] {
    BkClear,
    BkIdle,
    BkExec
  } bk_state_t;
endpackage

>>> rtl/host_heartbeat_liveness_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// host_heartbeat_liveness_table
// per-host heartbeat table: observe, query, mark and read request bits
// ----------------------------------------------------------------------------
// Requests go in by push while full is low; results come out by pop while
// empty is low, one result per request, in order. A two-entry queue sits
// behind the input so pushes are taken while the table works.
// In the table each request first reads its host entry from the single-port
// entry memories, then is classified or updated and written back.
// The table takes no new request until the last is written back; a push
// passes the input queue, the read and the update before empty goes low.
// After reset the table memories are cleared one entry a cycle, all 2048
// entries, during which requests queue but are not processed (full rises
// once two are queued). Configuration writes are taken at any time.
// If pop stays low the finished result holds and the next request waits.
// ----------------------------------------------------------------------------
module host_heartbeat_liveness_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [11:0] host_id,
  input  logic [31:0] now,
  input  logic [11:0] rec_owner_id,
  input  logic [63:0] rec_generation,
  input  logic [63:0] rec_timestamp,
  input  logic [15:0] rec_io_timeout,
  input  logic        requests_us,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [2:0]  host_state,
  output logic [63:0] out_generation,
  output logic [63:0] out_timestamp,
  output logic [15:0] out_io_timeout,
  output logic        record_changed,
  output logic        new_request,
  output logic        bitmap_bit,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import hhlt_pkg::*;

  cmd_t cmd;
  res_t res;
  logic cmd_valid, cmd_take, res_valid;
  logic [11:0] own_host_id;
  logic [15:0] own_io_timeout, fail_seconds, dead_seconds, req_gap_seconds;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_host_id <= 12'd1;
      own_io_timeout <= 16'd10;
      fail_seconds <= 16'd80;
      dead_seconds <= 16'd140;
      req_gap_seconds <= 16'd30;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgOwnId: own_host_id <= cfg_data[11:0];
        CfgOwnIot: own_io_timeout <= cfg_data;
        CfgFail: fail_seconds <= cfg_data;
        CfgDead: dead_seconds <= cfg_data;
        CfgReqFin: req_gap_seconds <= cfg_data;
        default: ;
      endcase
    end
  end

  hhlt_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .action(action),
    .host_id(host_id), .now(now), .rec_owner_id(rec_owner_id),
    .rec_generation(rec_generation), .rec_timestamp(rec_timestamp),
    .rec_io_timeout(rec_io_timeout), .requests_us(requests_us),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take));

  hhlt_back u_back (
    .clk(clk), .rst(rst), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
    .own_host_id(own_host_id), .own_io_timeout(own_io_timeout),
    .fail_seconds(fail_seconds), .dead_seconds(dead_seconds),
    .req_gap_seconds(req_gap_seconds),
    .res(res), .res_valid(res_valid), .res_take(pop));

  assign empty = !res_valid;
  assign status = res.status;
  assign host_state = res.host_state;
  assign out_generation = res.gen;
  assign out_timestamp = res.ts;
  assign out_io_timeout = res.iot;
  assign record_changed = res.changed;
  assign new_request = res.new_req;
  assign bitmap_bit = res.bit_out;
endmodule

>>> rtl/hhlt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhlt_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module hhlt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> rtl/hhlt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhlt_front
// accepts requests, checks host range and queues them for the back end
// ----------------------------------------------------------------------------
module hhlt_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [1:0]     action,
  input  logic [11:0]    host_id,
  input  logic [31:0]    now,
  input  logic [11:0]    rec_owner_id,
  input  logic [63:0]    rec_generation,
  input  logic [63:0]    rec_timestamp,
  input  logic [15:0]    rec_io_timeout,
  input  logic           requests_us,
  output hhlt_pkg::cmd_t cmd,
  output logic           cmd_valid,
  input  logic           cmd_take
);
  import hhlt_pkg::*;

  cmd_t q [2];
  logic wp, rp;
  logic [1:0] cnt;
  cmd_t c_in;
  logic [12:0] idx;

  always_comb begin
    idx = {1'b0, host_id} - 13'd1;
    c_in.action = action;
    c_in.bad = (host_id == 12'd0) || ({1'b0, host_id} > 13'(MaxHosts));
    c_in.h = idx[HostAw-1:0];
    c_in.host_id = host_id;
    c_in.now = now;
    c_in.owner = rec_owner_id;
    c_in.gen = rec_generation;
    c_in.ts = rec_timestamp;
    c_in.iot = rec_io_timeout;
    c_in.req = requests_us;
  end

  assign full = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push && !full) begin
        q[wp] <= c_in;
        wp <= ~wp;
      end
      if (cmd_take && cmd_valid) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'((push && !full) ? 1 : 0) - 2'((cmd_take && cmd_valid) ? 1 : 0);
    end
  end
endmodule

>>> rtl/hhlt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhlt_back
// reads a table entry, classifies or updates it, writes back, holds result
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module hhlt_back (
  input  logic           clk,
  input  logic           rst,
  input  hhlt_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_take,
  input  logic [11:0]    own_host_id,
  input  logic [15:0]    own_io_timeout,
  input  logic [15:0]    fail_seconds,
  input  logic [15:0]    dead_seconds,
  input  logic [15:0]    req_gap_seconds,
  output hhlt_pkg::res_t res,
  output logic           res_valid,
  input  logic           res_take
);
  import hhlt_pkg::*;

  bk_state_t state, state_next;
  logic [HostAw-1:0] clr_addr;
  logic any_checked;
  cmd_t c;
  logic [RecW-1:0] rec_rd, rec_wd;
  logic [TimW-1:0] tim_rd, tim_wd;
  logic rec_we, tim_we;
  logic [HostAw-1:0] addr;
  logic [11:0] s_owner;
  logic [63:0] s_gen, s_ts;
  logic [15:0] s_iot;
  logic [31:0] t_first, t_live, t_lreq, t_pend;
  logic [31:0] n_first, n_live, n_lreq, n_pend, last, gap;
  res_t r;
  logic same, changed;

  hhlt_ram #(.Width(RecW), .Depth(MaxHosts)) u_rec (
    .clk(clk), .we(rec_we), .addr(addr), .wdata(rec_wd), .rdata(rec_rd));
  hhlt_ram #(.Width(TimW), .Depth(MaxHosts)) u_tim (
    .clk(clk), .we(tim_we), .addr(addr), .wdata(tim_wd), .rdata(tim_rd));

  assign {s_owner, s_gen, s_ts, s_iot} = rec_rd;
  assign {t_first, t_live, t_lreq, t_pend} = tim_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BkClear;
      clr_addr <= '0;
      any_checked <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BkClear) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (res_take && res_valid) begin
        res_valid <= 1'b0;
      end
      if (state == BkExec) begin
        res_valid <= 1'b1;
        if (c.action == ActObserve && !c.bad) begin
          any_checked <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == BkIdle && cmd_take) begin
      c <= cmd;
    end
    if (state == BkExec) begin
      res <= r;
    end
  end

  // start a new entry only when the result slot will be free
  assign cmd_take = (state == BkIdle) && cmd_valid && (!res_valid || res_take);

  always_comb begin
    state_next = state;
    unique case (state)
      BkClear: if (clr_addr == HostAw'(ClearLen - 1)) state_next = BkIdle;
      BkIdle: if (cmd_take) state_next = BkExec;
      BkExec: state_next = BkIdle;
      default: state_next = BkIdle;
    endcase
  end

  always_comb begin
    same = (s_owner == c.owner) && (s_gen == c.gen) && (s_ts == c.ts);
    n_first = t_first;
    n_live = t_live;
    n_lreq = t_lreq;
    n_pend = t_pend;
    changed = 1'b0;
    r = '0;
    last = (t_live != 32'd0) ? t_live : t_first;
    gap = c.now - last;
    if (c.bad) begin
      r.status = StRange;
    end else begin
      unique case (c.action)
        ActObserve: begin
          if (t_first == 32'd0) n_first = c.now;
          if (!same) begin
            changed = 1'b1;
            r.changed = 1'b1;
            n_live = c.now;
            if (c.host_id != own_host_id && c.req &&
                (c.now - t_lreq) >= {16'd0, req_gap_seconds}) begin
              n_lreq = c.now;
              r.new_req = 1'b1;
            end
          end
        end
        ActQuery: begin
          if (!any_checked) begin
            r.status = StNoObs;
          end else begin
            r.gen = s_gen;
            r.ts = s_ts;
            r.iot = (s_iot != 16'd0) ? s_iot : own_io_timeout;
            priority if (s_ts == 64'd0) r.host_state = HsFree;
            else if ({20'd0, s_owner} == {20'd0, own_host_id}) r.host_state = HsLive;
            else if (gap <= {16'd0, fail_seconds})
              r.host_state = (t_first == t_live) ? HsUnknown : HsLive;
            else if (gap > {16'd0, dead_seconds}) r.host_state = HsDead;
            else r.host_state = HsFail;
          end
        end
        ActMark: n_pend = c.now;
        ActRead: begin
          if (c.host_id != own_host_id && t_pend != 32'd0) begin
            if ((c.now - t_pend) > {16'd0, req_gap_seconds}) n_pend = 32'd0;
            else r.bit_out = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    addr = (state == BkClear) ? clr_addr : ((state == BkIdle) ? cmd.h : c.h);
    rec_we = (state == BkClear) || (state == BkExec && changed && !c.bad);
    tim_we = (state == BkClear) || (state == BkExec && !c.bad);
    rec_wd = (state == BkClear) ? '0 : {c.owner, c.gen, c.ts, c.iot};
    tim_wd = (state == BkClear) ? '0 : {n_first, n_live, n_lreq, n_pend};
  end

  `ASSERT_NEVER(a_take_in_clear, clk, rst, cmd_take && state != BkIdle, "take outside idle")
  `ASSERT_AT(a_exec_one, clk, rst, state == BkExec |=> state == BkIdle, "exec lasts one cycle")
  `ASSERT_AT(a_res_set, clk, rst, state == BkExec |=> res_valid, "result not posted")
  `ASSERT_NEVER(a_write_idle, clk, rst, tim_we && state == BkIdle, "write while idle")
endmodule

>>> test/tb_host_heartbeat_liveness_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_host_heartbeat_liveness_table
// checks the heartbeat liveness table against a behavioral table model:
// directed rows first, then phased random traffic with idling on both sides
// ----------------------------------------------------------------------------
module tb_host_heartbeat_liveness_table;
  import hhlt_pkg::*;

  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] host_id;
    logic [31:0] now;
    logic [11:0] owner;
    logic [63:0] gen;
    logic [63:0] ts;
    logic [15:0] iot;
    logic        req;
  } hb_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  host_state;
    logic [63:0] gen;
    logic [63:0] ts;
    logic [15:0] iot;
    logic        changed;
    logic        new_req;
    logic        bit_out;
  } hb_res_t;

  logic        clk, rst, push, full, empty, pop, cfg_we;
  logic [1:0]  action;
  logic [11:0] host_id, rec_owner_id;
  logic [31:0] now;
  logic [63:0] rec_generation, rec_timestamp;
  logic [15:0] rec_io_timeout, cfg_data;
  logic        requests_us;
  logic [1:0]  status;
  logic [2:0]  host_state;
  logic [63:0] out_generation, out_timestamp;
  logic [15:0] out_io_timeout;
  logic        record_changed, new_request, bitmap_bit;
  logic [2:0]  cfg_index;

  host_heartbeat_liveness_table dut (.*);

  // table model
  logic [11:0] m_owner [MaxHosts];
  logic [63:0] m_gen [MaxHosts];
  logic [63:0] m_ts [MaxHosts];
  logic [15:0] m_iot [MaxHosts];
  logic [31:0] m_first [MaxHosts];
  logic [31:0] m_live [MaxHosts];
  logic [31:0] m_lreq [MaxHosts];
  logic [31:0] m_pend [MaxHosts];
  logic        m_checked;
  logic [11:0] r_own_id;
  logic [15:0] r_own_iot, r_fail, r_dead, r_fin;

  hb_res_t expected_q[$];
  int errors = 0;
  logic sink_idle_ok = 1'b1;
  logic long_hold = 1'b0;

  function automatic logic [2:0] host_class(int h, logic [31:0] t);
    logic [31:0] last, gap;
    if (m_ts[h] == 0) return HsFree;
    last = (m_live[h] != 0) ? m_live[h] : m_first[h];
    if ({20'd0, m_owner[h]} == {20'd0, r_own_id}) return HsLive;
    gap = t - last;
    if (gap <= {16'd0, r_fail}) return (m_first[h] == m_live[h]) ? HsUnknown : HsLive;
    if (gap > {16'd0, r_dead}) return HsDead;
    return HsFail;
  endfunction

  function automatic hb_res_t table_step(hb_req_t r);
    hb_res_t o;
    int h;
    o = '0;
    if (r.host_id == 0 || r.host_id > MaxHosts) begin
      o.status = StRange;
      return o;
    end
    h = r.host_id - 1;
    case (r.action)
      ActObserve: begin
        m_checked = 1'b1;
        if (m_first[h] == 0) m_first[h] = r.now;
        if (!(m_owner[h] == r.owner && m_gen[h] == r.gen && m_ts[h] == r.ts)) begin
          m_owner[h] = r.owner; m_gen[h] = r.gen; m_ts[h] = r.ts; m_iot[h] = r.iot;
          m_live[h] = r.now;
          o.changed = 1'b1;
          if (r.host_id != r_own_id && r.req &&
              (r.now - m_lreq[h]) >= {16'd0, r_fin}) begin
            m_lreq[h] = r.now;
            o.new_req = 1'b1;
          end
        end
      end
      ActQuery: begin
        if (!m_checked) o.status = StNoObs;
        else begin
          o.host_state = host_class(h, r.now);
          o.gen = m_gen[h];
          o.ts = m_ts[h];
          o.iot = (m_iot[h] != 0) ? m_iot[h] : r_own_iot;
        end
      end
      ActMark: m_pend[h] = r.now;
      default: begin
        if (r.host_id != r_own_id && m_pend[h] != 0) begin
          if ((r.now - m_pend[h]) > {16'd0, r_fin}) m_pend[h] = 0;
          else o.bit_out = 1'b1;
        end
      end
    endcase
    return o;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("host_heartbeat_liveness_table: mismatch");
    $finish;
  end

  // result side
  initial begin
    int gap, held;
    pop = 0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        pop = 0;
        for (held = 0; held < 300; held++) @(negedge clk);
        long_hold = 0;
      end
      if (sink_idle_ok && $urandom_range(0, 3) == 0) begin
        pop = 0;
        gap = $urandom_range(1, 16);
        repeat (gap) @(negedge clk);
      end
      pop = 1;
    end
  end

  always @(posedge clk) begin
    hb_res_t e;
    if (!rst && pop && !empty) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (status !== e.status) begin
          $error("status exp %0d got %0d", e.status, status); errors++;
        end
        if (host_state !== e.host_state) begin
          $error("host_state exp %0d got %0d", e.host_state, host_state); errors++;
        end
        if (out_generation !== e.gen) begin
          $error("out_generation exp %h got %h", e.gen, out_generation); errors++;
        end
        if (out_timestamp !== e.ts) begin
          $error("out_timestamp exp %h got %h", e.ts, out_timestamp); errors++;
        end
        if (out_io_timeout !== e.iot) begin
          $error("out_io_timeout exp %0d got %0d", e.iot, out_io_timeout); errors++;
        end
        if (record_changed !== e.changed) begin
          $error("record_changed exp %0d got %0d", e.changed, record_changed); errors++;
        end
        if (new_request !== e.new_req) begin
          $error("new_request exp %0d got %0d", e.new_req, new_request); errors++;
        end
        if (bitmap_bit !== e.bit_out) begin
          $error("bitmap_bit exp %0d got %0d", e.bit_out, bitmap_bit); errors++;
        end
      end
    end
  end

  logic src_idle_ok = 1'b1;

  task automatic send_request(hb_req_t r, logic check_fixed, hb_res_t fixed);
    hb_res_t p;
    int gap;
    if (src_idle_ok && $urandom_range(0, 4) == 0) begin
      push = 0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(negedge clk);
    end
    push = 1;
    action = r.action; host_id = r.host_id; now = r.now; rec_owner_id = r.owner;
    rec_generation = r.gen; rec_timestamp = r.ts; rec_io_timeout = r.iot;
    requests_us = r.req;
    @(posedge clk);
    while (full) @(posedge clk);
    p = table_step(r);
    if (check_fixed && p !== fixed) begin
      $error("directed row model disagrees, exp %h model %h", fixed, p);
      errors++;
    end
    expected_q.push_back(p);
    @(negedge clk);
    push = 0;
  endtask

  task automatic drain;
    int waited;
    push = 0;
    waited = 0;
    while (expected_q.size() != 0 && waited < 200000) begin
      @(negedge clk);
      waited++;
    end
    repeat (10) @(negedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [15:0] v);
    cfg_we = 1; cfg_index = idx; cfg_data = v;
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      CfgOwnId: r_own_id = v[11:0];
      CfgOwnIot: r_own_iot = v;
      CfgFail: r_fail = v;
      CfgDead: r_dead = v;
      default: r_fin = v;
    endcase
  endtask

  hb_req_t dir_req [20];
  hb_res_t dir_res [20];
  logic    dir_fix [20];

  function automatic hb_req_t mk(logic [1:0] a, logic [11:0] id, logic [31:0] t,
                                 logic [11:0] ow, logic [63:0] g, logic [63:0] s,
                                 logic [15:0] io, logic rq);
    hb_req_t r;
    r.action = a; r.host_id = id; r.now = t; r.owner = ow; r.gen = g; r.ts = s;
    r.iot = io; r.req = rq;
    return r;
  endfunction

  // random request; a small nhosts makes entries get revisited
  function automatic hb_req_t rand_req(logic [31:0] t, int nhosts);
    hb_req_t r;
    int k;
    r.action = 2'($urandom_range(0, 3));
    k = $urandom_range(0, 19);
    if (k == 0) r.host_id = 12'($urandom_range(0, 4095));
    else if (k == 1) r.host_id = 12'(MaxHosts);
    else r.host_id = 12'($urandom_range(1, nhosts));
    r.now = t;
    r.owner = ($urandom_range(0, 3) == 0) ? 12'($urandom) : r.host_id;
    r.gen = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 2));
    k = $urandom_range(0, 5);
    r.ts = (k == 0) ? 64'd0 : (k == 1) ? {$urandom, $urandom} : 64'($urandom_range(1, 3));
    r.iot = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
    r.req = 1'($urandom_range(0, 1));
    return r;
  endfunction

  initial begin
    logic [31:0] t;
    int i, ph;
    for (i = 0; i < MaxHosts; i++) begin
      m_owner[i] = 0; m_gen[i] = 0; m_ts[i] = 0; m_iot[i] = 0;
      m_first[i] = 0; m_live[i] = 0; m_lreq[i] = 0; m_pend[i] = 0;
    end
    m_checked = 0;
    r_own_id = 1; r_own_iot = 10; r_fail = 80; r_dead = 140; r_fin = 30;
    push = 0; action = 0; host_id = 0; now = 0; rec_owner_id = 0;
    rec_generation = 0; rec_timestamp = 0; rec_io_timeout = 0; requests_us = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    rst = 1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed rows: fixed result typed in where obvious
    for (i = 0; i < 20; i++) begin dir_fix[i] = 0; dir_res[i] = '0; end
    dir_req[0] = mk(ActQuery, 12'd5, 32'd100, 0, 0, 0, 0, 0);
    dir_fix[0] = 1; dir_res[0].status = StNoObs;
    dir_req[1] = mk(ActObserve, 12'd0, 32'd1, 0, 0, 0, 0, 0);
    dir_fix[1] = 1; dir_res[1].status = StRange;
    dir_req[2] = mk(ActQuery, 12'd2049, 32'd1, 0, 0, 0, 0, 0);
    dir_fix[2] = 1; dir_res[2].status = StRange;
    dir_req[3] = mk(ActObserve, 12'hfff, 32'hffffffff, 12'hfff, '1, '1, '1, 1);
    dir_fix[3] = 1; dir_res[3].status = StRange;
    dir_req[4] = mk(ActObserve, 12'd5, 32'd100, 12'd5, 64'd7, '1, 16'hffff, 1);
    dir_req[5] = mk(ActObserve, 12'd5, 32'd110, 12'd5, 64'd7, '1, 16'd3, 1);
    dir_req[6] = mk(ActQuery, 12'd5, 32'd120, 0, 0, 0, 0, 0);
    dir_req[7] = mk(ActObserve, 12'd5, 32'd200, 12'd5, 64'd8, '1, 16'd0, 1);
    dir_req[8] = mk(ActQuery, 12'd5, 32'd250, 0, 0, 0, 0, 0);
    dir_req[9] = mk(ActQuery, 12'd5, 32'd300, 0, 0, 0, 0, 0);
    dir_req[10] = mk(ActQuery, 12'd5, 32'd400, 0, 0, 0, 0, 0);
    dir_req[11] = mk(ActObserve, 12'd1, 32'd0, 12'd1, 64'd1, 64'd1, 0, 1);
    dir_req[12] = mk(ActQuery, 12'd1, 32'hfffffff0, 0, 0, 0, 0, 0);
    dir_req[13] = mk(ActMark, 12'd2048, 32'd500, 0, 0, 0, 0, 0);
    dir_req[14] = mk(ActRead, 12'd2048, 32'd530, 0, 0, 0, 0, 0);
    dir_req[15] = mk(ActRead, 12'd2048, 32'd531, 0, 0, 0, 0, 0);
    dir_req[16] = mk(ActRead, 12'd2048, 32'd532, 0, 0, 0, 0, 0);
    dir_fix[16] = 1;
    dir_req[17] = mk(ActMark, 12'd1, 32'd600, 0, 0, 0, 0, 0);
    dir_req[18] = mk(ActRead, 12'd1, 32'd601, 0, 0, 0, 0, 0);
    dir_fix[18] = 1;
    dir_req[19] = mk(ActQuery, 12'd2048, 32'd700, 0, 0, 0, 0, 0);
    for (i = 0; i < 20; i++) send_request(dir_req[i], dir_fix[i], dir_res[i]);
    drain();

    // random phases: register settings change in phases 1 to 4, idling stops in phase 5
    t = 32'd1000;
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        1: begin
          write_cfg(CfgOwnId, 16'd3); write_cfg(CfgOwnIot, 16'd1);
          write_cfg(CfgFail, 16'd0); write_cfg(CfgDead, 16'd0); write_cfg(CfgReqFin, 16'd0);
        end
        2: begin
          write_cfg(CfgOwnId, 16'd2048); write_cfg(CfgOwnIot, 16'hffff);
          write_cfg(CfgFail, 16'hffff); write_cfg(CfgDead, 16'hffff);
          write_cfg(CfgReqFin, 16'hffff);
        end
        3: begin
          write_cfg(CfgOwnId, 16'hf002); write_cfg(CfgFail, 16'd20);
          write_cfg(CfgDead, 16'd5); write_cfg(CfgReqFin, 16'd4);
        end
        4: begin
          write_cfg(CfgOwnId, 16'd4); write_cfg(CfgOwnIot, 16'h5a5a);
          write_cfg(CfgFail, 16'd10); write_cfg(CfgDead, 16'd30); write_cfg(CfgReqFin, 16'd8);
        end
        5: begin
          src_idle_ok = 0; sink_idle_ok = 0;
        end
        default: ;
      endcase
      if (ph == 2) long_hold = 1;
      for (i = 0; i < 150; i++) begin
        if ($urandom_range(0, 9) == 0) t = 32'($urandom);
        else t = t + $urandom_range(0, 12);
        send_request(rand_req(t, (ph == 2) ? MaxHosts : 6), 1'b0, '0);
      end
      // sender waits until everything is back or the wait limit runs out
      drain();
    end

    if (errors == 0 && expected_q.size() == 0) begin
      $display("host_heartbeat_liveness_table: match");
    end else begin
      $display("host_heartbeat_liveness_table: mismatch");
    end
    $finish;
  end
endmodule
